### rtl/nlp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Two-pole lowpass package
// Shared constants, the sequencer state type and the elaboration-time
// exponential series from which the pole and tanh tables are built.
// ----------------------------------------------------------------------------
package nlp_pkg;

	localparam int SAMPLE_WIDTH_DEF     = 16;
	localparam int STATE_WIDTH_DEF      = 24;
	localparam int EXP_TABLE_DEPTH_DEF  = 256;
	localparam int TANH_TABLE_DEPTH_DEF = 256;

	localparam int CUTOFF_W = 16;
	localparam int RES_W    = 16;
	localparam int RATE_W   = 18;
	localparam int DIVD_W   = 35;
	localparam int U_W      = 20;
	localparam int TAB_W    = 31;

	localparam logic [RATE_W-1:0] RATE_RESET = 18'd44100;

	localparam logic [18:0] TWO_PI_Q16 = 19'd411775;
	localparam logic [16:0] LOG2E_Q16  = 17'd94548;
	localparam logic [63:0] LN2_Q20    = 64'd726817;
	localparam logic [63:0] EINV_Q32   = 64'd1580030169;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_M1,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_M2,
		ST_V,
		ST_M3,
		ST_EIDX,
		ST_M4,
		ST_M5,
		ST_T,
		ST_M6,
		ST_FB,
		ST_M7,
		ST_TIDX,
		ST_M8,
		ST_M9,
		ST_MAG,
		ST_M10,
		ST_M11,
		ST_ST1,
		ST_M12,
		ST_M13,
		ST_ST2,
		ST_DONE
	} state_t;

	// e^-z with z in Q.20, result in Q.32; only ever evaluated at elaboration.
	function automatic logic [63:0] exp_neg_q32(input logic [63:0] z);
		logic [63:0] m;
		logic [63:0] r;
		logic [63:0] term;
		logic [63:0] pos;
		logic [63:0] neg;
		logic [63:0] res;
		m    = z >> 20;
		r    = z & 64'hFFFFF;
		term = 64'd1 << 40;
		pos  = 64'd1 << 40;
		neg  = 64'd0;
		for (int k = 1; k <= 16; k++) begin
			term = ((term * r) >> 20) / 64'(k);
			if ((k % 2) == 1) begin
				neg = neg + term;
			end else begin
				pos = pos + term;
			end
		end
		res = (pos - neg) >> 8;
		if (m >= 64'd40) begin
			res = 64'd0;
		end else begin
			for (int j = 0; j < 40; j++) begin
				if (64'(j) < m) begin
					res = (res * EINV_Q32) >> 32;
				end
			end
		end
		return res;
	endfunction

endpackage
`default_nettype wire

### rtl/nlp_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned division, one quotient bit per cycle, most significant first.
// ----------------------------------------------------------------------------
module nlp_div #(
	parameter int DW = nlp_pkg::DIVD_W,
	parameter int VW = nlp_pkg::RATE_W
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] dividend,
	input  wire logic [VW-1:0] divisor,
	output logic               done,
	output logic [DW-1:0]      quotient
);

	localparam int CW = $clog2(DW + 1);

	logic [CW-1:0] cnt_q;
	logic [VW-1:0] rem_q;
	logic [DW-1:0] quo_q;
	logic          done_q;
	logic [VW:0]   trial;
	logic          take;

	assign trial = {rem_q, quo_q[DW-1]};
	assign take  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(DW);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - 1'b1;
				done_q <= (cnt_q == CW'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= take ? VW'(trial - {1'b0, divisor}) : VW'(trial);
			quo_q <= {quo_q[DW-2:0], take};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

### rtl/nonlinear_two_pole_lowpass.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Nonlinear two-pole lowpass
// Two cascaded one-pole stages with tanh-shaped resonance feedback, worked
// through one shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// The 35-step restoring divide that turns the cutoff into a normalised
// frequency consists of a start step, the 35 steps and a step to see it
// finish. The other steps each drive the single shared multiplier once or
// consume its registered product, but for the completion step. A zero
// sample rate skips the divide and the pole lookup; a pole that underflows
// to zero skips the exponential lookup, and a feedback argument of four or
// more skips the tanh lookup. The block is not ready while a sample is in
// flight, and a finished sample waits in the output register, so the next
// sample may be accepted before the last result is taken; if the previous
// result has still not been taken when the next one is finished, the
// completion step waits for it. The filter state resets to zero and sample
// rate to 44100.
module nonlinear_two_pole_lowpass #(
	parameter int SAMPLE_WIDTH     = nlp_pkg::SAMPLE_WIDTH_DEF,
	parameter int STATE_WIDTH      = nlp_pkg::STATE_WIDTH_DEF,
	parameter int EXP_TABLE_DEPTH  = nlp_pkg::EXP_TABLE_DEPTH_DEF,
	parameter int TANH_TABLE_DEPTH = nlp_pkg::TANH_TABLE_DEPTH_DEF,
	localparam int STD = ((SAMPLE_WIDTH + 32 + 7) / 8) * 8,
	localparam int MTD = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	// sample_in, cutoff_hz, resonance, then zero padding
	input  wire logic [STD-1:0]             s_tdata,
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	// sample_out, then zero padding
	output logic [MTD-1:0]                  m_tdata,
	input  wire logic                       cfg_wen,
	input  wire logic [nlp_pkg::RATE_W-1:0] cfg_wdata
);

	localparam int SW   = SAMPLE_WIDTH;
	localparam int W    = STATE_WIDTH;
	localparam int SF   = SW - 1;
	localparam int STF  = W - 4;
	localparam int WA   = (W + 1 > 35) ? W + 1 : 35;
	localparam int WB   = 20;
	localparam int WP   = WA + WB;
	localparam int XW   = SW + W;
	localparam int MW   = nlp_pkg::TAB_W + W;
	localparam int IWE  = $clog2(EXP_TABLE_DEPTH + 1);
	localparam int IWT  = $clog2(TANH_TABLE_DEPTH + 1);
	localparam int SHLX = (STF >= SF) ? STF - SF : 0;
	localparam int SHRX = (SF > STF) ? SF - STF : 0;
	localparam int MSHL = (STF >= 30) ? STF - 30 : 0;
	localparam int MSHR = (STF < 30) ? 30 - STF : 0;
	localparam int FB   = STF + 12;
	localparam int FSHR = (FB >= 32) ? FB - 32 : 0;
	localparam int FSHL = (FB < 32) ? 32 - FB : 0;
	localparam logic [63:0] ONE = 64'd1 << 32;

	// Constant tables
	logic [16:0]                 exp_rom  [0:EXP_TABLE_DEPTH];
	logic [nlp_pkg::TAB_W-1:0]   tanh_rom [0:TANH_TABLE_DEPTH];

	for (genvar gi = 0; gi <= EXP_TABLE_DEPTH; gi++) begin : g_exp
		localparam logic [63:0] Z = (64'(gi) * nlp_pkg::LN2_Q20) / EXP_TABLE_DEPTH;
		localparam logic [63:0] E = nlp_pkg::exp_neg_q32(Z);
		assign exp_rom[gi] = 17'((E + 64'd32768) >> 16);
	end

	for (genvar gi = 0; gi <= TANH_TABLE_DEPTH; gi++) begin : g_tanh
		localparam logic [63:0] Z   = ((64'(gi) * 64'd8) << 20) / TANH_TABLE_DEPTH;
		localparam logic [63:0] E   = nlp_pkg::exp_neg_q32(Z);
		localparam logic [63:0] DEN = ONE + E;
		localparam logic [63:0] V   = (((ONE - E) << 30) + DEN / 2) / DEN;
		assign tanh_rom[gi] = nlp_pkg::TAB_W'(V);
	end

	nlp_pkg::state_t state_q, state_d;

	logic [nlp_pkg::RATE_W-1:0]   rate_q;
	logic signed [SW-1:0]         x_q;
	logic [nlp_pkg::CUTOFF_W-1:0] cutoff_q;
	logic [nlp_pkg::RES_W-1:0]    res_q;
	logic [nlp_pkg::U_W-1:0]      u_q;
	logic [4:0]                   n_q;
	logic [15:0]                  phi_q;
	logic [nlp_pkg::TAB_W-1:0]    tab0_q, tab1_q;
	logic [15:0]                  w_q;
	logic [15:0]                  t_q;
	logic [33:0]                  p32_q;
	logic signed [W-1:0]          s_q;
	logic signed [W-1:0]          st1_q, st2_q;
	logic signed [SW-1:0]         out_q;
	logic                         out_valid_q;
	logic signed [WP-1:0]         prod_q, acc_q;

	logic signed [WA-1:0]         mul_a;
	logic signed [WB-1:0]         mul_b;
	logic signed [WP:0]           sum;
	logic signed [WP:0]           sum_sh;
	logic [16:0]                  omt;
	logic signed [W:0]            st2_ext, st2_abs;
	logic signed [XW-1:0]         xs_wide, y_wide;
	logic signed [W:0]            xs_m_s, st1_p_s;
	logic [nlp_pkg::TAB_W-1:0]    mag;
	logic [MW-1:0]                mag_st;
	logic signed [W-1:0]          s_new;
	logic signed [W-1:0]          st_new;
	logic [WP-1:0]                p32_wide;
	logic [16:0]                  t_full;
	logic [IWE-1:0]               eidx;
	logic [IWT-1:0]               tidx;
	logic                         fb_big;
	logic                         div_start, div_done;
	logic [nlp_pkg::DIVD_W-1:0]   div_q;
	logic                         load_out;

	nlp_div #(
		.DW(nlp_pkg::DIVD_W),
		.VW(nlp_pkg::RATE_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(prod_q[nlp_pkg::DIVD_W-1:0]),
		.divisor (rate_q),
		.done    (div_done),
		.quotient(div_q)
	);

	assign omt     = 17'h10000 - 17'(t_q);
	assign st2_ext = (W + 1)'(st2_q);
	assign st2_abs = st2_q[W-1] ? -st2_ext : st2_ext;
	assign xs_wide = (XW'(x_q) <<< SHLX) >>> SHRX;
	assign xs_m_s  = (W + 1)'(xs_wide) - (W + 1)'(s_q);
	assign st1_p_s = (W + 1)'(st1_q) + (W + 1)'(s_q);
	assign sum     = {acc_q[WP-1], acc_q} + {prod_q[WP-1], prod_q};
	assign sum_sh  = sum >>> 16;
	assign fb_big  = |prod_q[WP-1:FB+2];
	assign p32_wide = (WP'(prod_q) >> FSHR) << FSHL;
	assign t_full  = sum[32:16] >> n_q;
	assign eidx    = prod_q[16 +: IWE];
	assign tidx    = prod_q[34 +: IWT];

	// Feedback magnitude: full scale when the tanh argument reaches four.
	assign mag    = (state_q == nlp_pkg::ST_FB) ? nlp_pkg::TAB_W'(64'd1 << 30) : sum[46:16];
	assign mag_st = (MW'(mag) << MSHL) >> MSHR;
	assign s_new  = st2_q[W-1] ? -W'(mag_st) : W'(mag_st);

	always_comb begin
		if ((sum_sh[WP:W-1] == '0) || (sum_sh[WP:W-1] == '1)) begin
			st_new = W'(sum_sh);
		end else if (sum_sh[WP]) begin
			st_new = {1'b1, {(W - 1){1'b0}}};
		end else begin
			st_new = {1'b0, {(W - 1){1'b1}}};
		end
	end

	assign y_wide = (XW'(st2_q) <<< SHRX) >>> SHLX;

	// Operand selection for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			nlp_pkg::ST_M1: begin
				mul_a = WA'(cutoff_q);
				mul_b = WB'(nlp_pkg::TWO_PI_Q16);
			end
			nlp_pkg::ST_M2: begin
				mul_a = WA'(u_q);
				mul_b = WB'(nlp_pkg::LOG2E_Q16);
			end
			nlp_pkg::ST_M3: begin
				mul_a = WA'(phi_q);
				mul_b = WB'(EXP_TABLE_DEPTH);
			end
			nlp_pkg::ST_M4, nlp_pkg::ST_M8: begin
				mul_a = WA'(tab0_q);
				mul_b = WB'(17'h10000 - 17'(w_q));
			end
			nlp_pkg::ST_M5, nlp_pkg::ST_M9: begin
				mul_a = WA'(tab1_q);
				mul_b = WB'(w_q);
			end
			nlp_pkg::ST_M6: begin
				mul_a = WA'(st2_abs);
				mul_b = WB'(res_q);
			end
			nlp_pkg::ST_M7: begin
				mul_a = WA'(p32_q);
				mul_b = WB'(TANH_TABLE_DEPTH);
			end
			nlp_pkg::ST_M10: begin
				mul_a = WA'(xs_m_s);
				mul_b = WB'(omt);
			end
			nlp_pkg::ST_M11: begin
				mul_a = WA'(st1_q);
				mul_b = WB'(t_q);
			end
			nlp_pkg::ST_M12: begin
				mul_a = WA'(st1_p_s);
				mul_b = WB'(omt);
			end
			nlp_pkg::ST_M13: begin
				mul_a = WA'(st2_q);
				mul_b = WB'(t_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Sequencer
	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			nlp_pkg::ST_IDLE:      if (s_tvalid) state_d = nlp_pkg::ST_M1;
			nlp_pkg::ST_M1:        state_d = (rate_q == '0) ? nlp_pkg::ST_M6
			                                                : nlp_pkg::ST_DIV_START;
			nlp_pkg::ST_DIV_START: begin
				div_start = 1'b1;
				state_d   = nlp_pkg::ST_DIV_WAIT;
			end
			nlp_pkg::ST_DIV_WAIT:  if (div_done) state_d = nlp_pkg::ST_M2;
			nlp_pkg::ST_M2:        state_d = nlp_pkg::ST_V;
			nlp_pkg::ST_V:         state_d = (prod_q[36:32] >= 5'd17) ? nlp_pkg::ST_M6
			                                                          : nlp_pkg::ST_M3;
			nlp_pkg::ST_M3:        state_d = nlp_pkg::ST_EIDX;
			nlp_pkg::ST_EIDX:      state_d = nlp_pkg::ST_M4;
			nlp_pkg::ST_M4:        state_d = nlp_pkg::ST_M5;
			nlp_pkg::ST_M5:        state_d = nlp_pkg::ST_T;
			nlp_pkg::ST_T:         state_d = nlp_pkg::ST_M6;
			nlp_pkg::ST_M6:        state_d = nlp_pkg::ST_FB;
			nlp_pkg::ST_FB:        state_d = fb_big ? nlp_pkg::ST_M10 : nlp_pkg::ST_M7;
			nlp_pkg::ST_M7:        state_d = nlp_pkg::ST_TIDX;
			nlp_pkg::ST_TIDX:      state_d = nlp_pkg::ST_M8;
			nlp_pkg::ST_M8:        state_d = nlp_pkg::ST_M9;
			nlp_pkg::ST_M9:        state_d = nlp_pkg::ST_MAG;
			nlp_pkg::ST_MAG:       state_d = nlp_pkg::ST_M10;
			nlp_pkg::ST_M10:       state_d = nlp_pkg::ST_M11;
			nlp_pkg::ST_M11:       state_d = nlp_pkg::ST_ST1;
			nlp_pkg::ST_ST1:       state_d = nlp_pkg::ST_M12;
			nlp_pkg::ST_M12:       state_d = nlp_pkg::ST_M13;
			nlp_pkg::ST_M13:       state_d = nlp_pkg::ST_ST2;
			nlp_pkg::ST_ST2:       state_d = nlp_pkg::ST_DONE;
			nlp_pkg::ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = nlp_pkg::ST_IDLE;
				end
			end
			default:               state_d = nlp_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= nlp_pkg::ST_IDLE;
			rate_q      <= nlp_pkg::RATE_RESET;
			st1_q       <= '0;
			st2_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wen) begin
				rate_q <= cfg_wdata;
			end
			if (state_q == nlp_pkg::ST_ST1) begin
				st1_q <= st_new;
			end
			if (state_q == nlp_pkg::ST_ST2) begin
				st2_q <= st_new;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			nlp_pkg::ST_IDLE: begin
				x_q      <= s_tdata[SW-1:0];
				cutoff_q <= s_tdata[SW+15:SW];
				res_q    <= s_tdata[SW+31:SW+16];
			end
			nlp_pkg::ST_M1: t_q <= '0;
			nlp_pkg::ST_DIV_WAIT: begin
				u_q <= (div_q[nlp_pkg::DIVD_W-1:nlp_pkg::U_W] != '0) ? '1
				       : div_q[nlp_pkg::U_W-1:0];
			end
			nlp_pkg::ST_V: begin
				n_q   <= prod_q[36:32];
				phi_q <= prod_q[31:16];
			end
			nlp_pkg::ST_EIDX: begin
				tab0_q <= nlp_pkg::TAB_W'(exp_rom[eidx]);
				tab1_q <= nlp_pkg::TAB_W'(exp_rom[eidx + 1'b1]);
				w_q    <= prod_q[15:0];
			end
			nlp_pkg::ST_TIDX: begin
				tab0_q <= tanh_rom[tidx];
				tab1_q <= tanh_rom[tidx + 1'b1];
				w_q    <= prod_q[33:18];
			end
			nlp_pkg::ST_M5, nlp_pkg::ST_M9, nlp_pkg::ST_M11, nlp_pkg::ST_M13: begin
				acc_q <= prod_q;
			end
			nlp_pkg::ST_T:   t_q <= t_full[16] ? 16'hFFFF : t_full[15:0];
			nlp_pkg::ST_FB: begin
				p32_q <= p32_wide[33:0];
				s_q   <= s_new;
			end
			nlp_pkg::ST_MAG: s_q <= s_new;
			nlp_pkg::ST_DONE: begin
				if (load_out) begin
					if ((y_wide[XW-1:SW-1] == '0) || (y_wide[XW-1:SW-1] == '1)) begin
						out_q <= SW'(y_wide);
					end else if (y_wide[XW-1]) begin
						out_q <= {1'b1, {(SW - 1){1'b0}}};
					end else begin
						out_q <= {1'b0, {(SW - 1){1'b1}}};
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign s_tready = (state_q == nlp_pkg::ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = MTD'($unsigned(out_q));

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("sample accepted while a transaction was in flight");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == nlp_pkg::ST_DONE)
		else $error("result raised outside the completion step");

	a_stage_one_update: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(st1_q) |-> $past(state_q) == nlp_pkg::ST_ST1)
		else $error("first stage changed outside its update step");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> rate_q != '0)
		else $error("divide started with a zero sample rate");

endmodule
`default_nettype wire
